// ----- rtl/cbdf_pkg.sv -----
// cbdf_pkg: shared constants and types for the coverage bitmap duplicate filter
// used by cbdf_bitmap and coverage_bitmap_duplicate_filter; no dependencies
`timescale 1ns / 1ps

package cbdf_pkg;

  // default sizes
  localparam int POSITION_DEPTH_DEF = 4096;
  localparam int MAX_GROUPS_DEF     = 256;

  // fixed field widths
  localparam int POS_W   = 12;
  localparam int INDEX_W = 64;
  localparam int COUNT_W = 13;

  // group tallies saturate here
  localparam logic [COUNT_W-1:0] GROUP_COUNT_MAX = 13'd4096;

  // bitmap sequencer states
  typedef enum logic {
    BM_CLEAR,
    BM_READY
  } bm_state_t;

endpackage

// ----- rtl/cbdf_bitmap.sv -----
// cbdf_bitmap: one-bit coverage memory with registered read and a clearing sweep
// depends on cbdf_pkg (default depth and sequencer state type)
`timescale 1ns / 1ps

module cbdf_bitmap #(
  parameter int POSITION_DEPTH = cbdf_pkg::POSITION_DEPTH_DEF,
  localparam int AW = (POSITION_DEPTH > 1) ? $clog2(POSITION_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          set_en,
  input  logic [AW-1:0] set_addr,
  input  logic          clear_start,
  output logic          busy
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(POSITION_DEPTH - 1);

  logic                mem [POSITION_DEPTH];
  logic                rd_data_r;
  cbdf_pkg::bm_state_t state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                wr_data;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbdf_pkg::BM_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = cbdf_pkg::BM_READY;
      end
      cbdf_pkg::BM_READY: begin
        if (clear_start) state_nxt = cbdf_pkg::BM_CLEAR;
      end
      default: state_nxt = cbdf_pkg::BM_CLEAR;
    endcase
  end

  // outputs: sweep writes zero, otherwise the set port writes one
  always_comb begin
    busy         = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = set_addr;
    wr_data      = 1'b1;
    clr_addr_nxt = '0;
    case (state_r)
      cbdf_pkg::BM_CLEAR: begin
        busy         = 1'b1;
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = 1'b0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      cbdf_pkg::BM_READY: begin
        wr_en = set_en;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cbdf_pkg::BM_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/coverage_bitmap_duplicate_filter.sv -----
// coverage_bitmap_duplicate_filter: top level of the first-occurrence filter
// depends on cbdf_pkg and cbdf_bitmap
`timescale 1ns / 1ps

// usage
//   input channel (in_*): one request per (position, index) pair, with group_end
//   and set_end marking the last pair of a receive group and of the whole set
//   result channel (out_*): exactly one request per input request, in order
//   config: cfg_wr_en / cfg_wr_data write num_positions while the block is idle
// pipeline: an accepted input is held in the read stage while the bitmap is read
//   at the accepting edge, then checked, set and written into the output register
// throughput: one pair per cycle when in_stall is low; the read/write loop on the
//   bitmap memory is closed by forwarding a bit set by the item just ahead
// set end: the bitmap is swept to zero one entry a cycle, during which in_stall
//   is high; the pair after a set end is held off while the set end is in the read
//   stage, so that it waits for the sweep to start
// reset: the same sweep after rst_n, tallies cleared,
//   num_positions back to zero
// stall: when out_stall holds the output register, the item in the read stage
//   waits and in_stall goes high; nothing is committed until it can move
module coverage_bitmap_duplicate_filter #(
  parameter int POSITION_DEPTH = cbdf_pkg::POSITION_DEPTH_DEF,
  parameter int MAX_GROUPS     = cbdf_pkg::MAX_GROUPS_DEF,
  localparam int NGW           = $clog2(MAX_GROUPS + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_wr_en,
  input  logic        [cbdf_pkg::COUNT_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic        [cbdf_pkg::POS_W-1:0]      in_position,
  input  logic signed [cbdf_pkg::INDEX_W-1:0]    in_index_value,
  input  logic                                   in_group_end,
  input  logic                                   in_set_end,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_kept,
  output logic                                   out_out_of_range,
  output logic        [cbdf_pkg::POS_W-1:0]      out_kept_position,
  output logic signed [cbdf_pkg::INDEX_W-1:0]    out_removed_index,
  output logic        [cbdf_pkg::COUNT_W-1:0]    out_group_kept_count,
  output logic        [cbdf_pkg::COUNT_W-1:0]    out_group_removed_count,
  output logic        [NGW-1:0]                  out_nonempty_groups,
  output logic                                   out_all_covered,
  output logic                                   out_summary_valid
);

  localparam int AW  = (POSITION_DEPTH > 1) ? $clog2(POSITION_DEPTH) : 1;
  localparam int PW  = (AW > cbdf_pkg::POS_W) ? AW : cbdf_pkg::POS_W;
  localparam int DW  = PW + 1;
  localparam int CW  = cbdf_pkg::COUNT_W;
  localparam int PSW = cbdf_pkg::POS_W;
  localparam int IW  = cbdf_pkg::INDEX_W;

  // configuration register
  logic [CW-1:0] num_positions_r;

  // read stage: pair waiting for its bitmap bit
  logic                 s1_valid_r;
  logic [PSW-1:0]       s1_pos_r;
  logic signed [IW-1:0] s1_idx_r;
  logic                 s1_gend_r;
  logic                 s1_send_r;
  logic                 s1_fwd_r;

  // running tallies
  logic [CW-1:0]  cov_r, cov_nxt;
  logic [CW-1:0]  gk_r, gk_nxt;
  logic [CW-1:0]  gr_r, gr_nxt;
  logic [NGW-1:0] ne_r, ne_nxt;

  // output register
  logic                 out_valid_r;
  logic                 out_kept_r;
  logic                 out_oor_r;
  logic [PSW-1:0]       out_kpos_r;
  logic signed [IW-1:0] out_ridx_r;
  logic [CW-1:0]        out_gk_r;
  logic [CW-1:0]        out_gr_r;
  logic [NGW-1:0]       out_ne_r;
  logic                 out_allcov_r;
  logic                 out_sumv_r;

  // handshake and datapath
  logic          bm_busy;
  logic          bm_rd_data;
  logic          out_free;
  logic          commit;
  logic          accept;
  logic [PW-1:0] in_pos_w;
  logic [PW-1:0] s1_pos_w;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] s1_addr;
  logic          s1_bad;
  logic          s1_seen;
  logic          s1_keep;
  logic          s1_glast;
  logic          fwd_nxt;
  logic [CW-1:0] gk_upd;
  logic [CW-1:0] gr_upd;
  logic [NGW-1:0] ne_upd;
  logic [CW-1:0]  cov_upd;

  // positions widened so that any bitmap depth addresses correctly
  assign in_pos_w = PW'(in_position);
  assign s1_pos_w = PW'(s1_pos_r);
  assign in_addr  = in_pos_w[AW-1:0];
  assign s1_addr  = s1_pos_w[AW-1:0];

  // output register frees when empty or taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = s1_valid_r && out_free;

  // a set end must reach the sweep before the next pair reads the bitmap
  assign accept   = in_valid && !in_stall;
  assign in_stall = bm_busy || (s1_valid_r && (!out_free || s1_send_r));

  // check-and-set decision
  assign s1_bad   = ({1'b0, s1_pos_r} >= num_positions_r) ||
                    (DW'(s1_pos_r) >= DW'(POSITION_DEPTH));
  assign s1_seen  = bm_rd_data || s1_fwd_r;
  assign s1_keep  = !s1_bad && !s1_seen;
  assign s1_glast = s1_gend_r || s1_send_r;

  // bit set by the committing pair is not yet visible to a read at the same edge
  assign fwd_nxt  = commit && s1_keep && (s1_addr == in_addr);

  // tally updates including this pair
  always_comb begin
    gk_upd  = gk_r;
    gr_upd  = gr_r;
    cov_upd = cov_r;
    ne_upd  = ne_r;
    if (s1_keep) begin
      cov_upd = cov_r + CW'(1);
      if (gk_r < cbdf_pkg::GROUP_COUNT_MAX) gk_upd = gk_r + CW'(1);
    end else if (!s1_bad) begin
      if (gr_r < cbdf_pkg::GROUP_COUNT_MAX) gr_upd = gr_r + CW'(1);
    end
    if (s1_glast && (gk_upd != '0) && (ne_r < NGW'(MAX_GROUPS))) begin
      ne_upd = ne_r + NGW'(1);
    end
  end

  // next values after the group or set closes
  always_comb begin
    gk_nxt  = gk_r;
    gr_nxt  = gr_r;
    cov_nxt = cov_r;
    ne_nxt  = ne_r;
    if (commit) begin
      gk_nxt  = s1_glast ? '0 : gk_upd;
      gr_nxt  = s1_glast ? '0 : gr_upd;
      cov_nxt = s1_send_r ? '0 : cov_upd;
      ne_nxt  = s1_send_r ? '0 : ne_upd;
    end
  end

  // control and tallies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_positions_r <= '0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      cov_r           <= '0;
      gk_r            <= '0;
      gr_r            <= '0;
      ne_r            <= '0;
    end else begin
      if (cfg_wr_en) num_positions_r <= cfg_wr_data;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      cov_r <= cov_nxt;
      gk_r  <= gk_nxt;
      gr_r  <= gr_nxt;
      ne_r  <= ne_nxt;
    end
  end

  // read-stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r  <= in_position;
      s1_idx_r  <= in_index_value;
      s1_gend_r <= in_group_end;
      s1_send_r <= in_set_end;
      s1_fwd_r  <= fwd_nxt;
    end
  end

  // result payload, totals zero outside group and set ends
  always_ff @(posedge clk) begin
    if (commit) begin
      out_kept_r   <= s1_keep;
      out_oor_r    <= s1_bad;
      out_kpos_r   <= s1_keep ? s1_pos_r : '0;
      out_ridx_r   <= s1_keep ? '0 : s1_idx_r;
      out_gk_r     <= s1_glast ? gk_upd : '0;
      out_gr_r     <= s1_glast ? gr_upd : '0;
      out_ne_r     <= s1_send_r ? ne_upd : '0;
      out_allcov_r <= s1_send_r && (cov_upd == num_positions_r);
      out_sumv_r   <= s1_glast;
    end
  end

  cbdf_bitmap #(
    .POSITION_DEPTH(POSITION_DEPTH)
  ) u_bitmap (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (in_addr),
    .rd_data    (bm_rd_data),
    .set_en     (commit && s1_keep),
    .set_addr   (s1_addr),
    .clear_start(commit && s1_send_r),
    .busy       (bm_busy)
  );

  assign out_valid               = out_valid_r;
  assign out_kept                = out_kept_r;
  assign out_out_of_range        = out_oor_r;
  assign out_kept_position       = out_kpos_r;
  assign out_removed_index       = out_ridx_r;
  assign out_group_kept_count    = out_gk_r;
  assign out_group_removed_count = out_gr_r;
  assign out_nonempty_groups     = out_ne_r;
  assign out_all_covered         = out_allcov_r;
  assign out_summary_valid       = out_sumv_r;

  // a committed set end starts the bitmap sweep
  a_set_end_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && s1_send_r) |=> bm_busy)
    else $error("bitmap sweep did not start after set end");

  // a kept pair is never out of range
  a_keep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_kept_r && out_oor_r))
    else $error("kept and out_of_range both set");

  // group tallies stay within saturation
  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (gk_r <= cbdf_pkg::GROUP_COUNT_MAX) && (gr_r <= cbdf_pkg::GROUP_COUNT_MAX))
    else $error("group tally beyond saturation");

  // a pair held by a stalled output keeps its place and position
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_pos_r)))
    else $error("read stage lost a pair under stall");

  // no pair is taken just after a set end commits, while the sweep starts
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $past(commit && s1_send_r) |-> !accept)
    else $error("pair accepted before sweep");

endmodule

// ----- verif/coverage_bitmap_duplicate_filter_test.sv -----
// self-checking testbench for coverage_bitmap_duplicate_filter: a directed table,
// then random sets of receive groups, each result checked against a typed-in outcome or a built-in predictor
// depends on cbdf_pkg and the coverage_bitmap_duplicate_filter rtl
`timescale 1ns / 1ps

module coverage_bitmap_duplicate_filter_test;

  localparam int POSITION_DEPTH = cbdf_pkg::POSITION_DEPTH_DEF;
  localparam int MAX_GROUPS     = cbdf_pkg::MAX_GROUPS_DEF;
  localparam int NGW            = $clog2(MAX_GROUPS + 1);
  localparam int POS_W          = cbdf_pkg::POS_W;
  localparam int INDEX_W        = cbdf_pkg::INDEX_W;
  localparam int COUNT_W        = cbdf_pkg::COUNT_W;

  // stimulus sizing and run limits
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned QUIET_ITEMS  = 60;         // tail with no idling
  localparam int unsigned CYCLE_LIMIT  = 10_000_000; // sweeps dominate
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam logic signed [INDEX_W-1:0] INDEX_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [INDEX_W-1:0] INDEX_MIN = 64'sh8000_0000_0000_0000;

  // one request on the input channel
  typedef struct packed {
    logic [POS_W-1:0]          position;
    logic signed [INDEX_W-1:0] index_value;
    logic                      group_end;
    logic                      set_end;
  } pair_t;

  // one request on the result channel
  typedef struct packed {
    logic                      kept;
    logic                      out_of_range;
    logic [POS_W-1:0]          kept_position;
    logic signed [INDEX_W-1:0] removed_index;
    logic [COUNT_W-1:0]        group_kept_count;
    logic [COUNT_W-1:0]        group_removed_count;
    logic [NGW-1:0]            nonempty_groups;
    logic                      all_covered;
    logic                      summary_valid;
  } outcome_t;

  localparam outcome_t NO_OUTCOME = '0;

  // directed row: optional register write ahead of the pair, optional typed-in outcome
  typedef struct {
    bit                 do_cfg;
    logic [COUNT_W-1:0] cfg_value;
    pair_t              pair;
    bit                 has_outcome;
    outcome_t           outcome;
  } stim_row_t;

  // dut ports
  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [COUNT_W-1:0]        cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [POS_W-1:0]          in_position;
  logic signed [INDEX_W-1:0] in_index_value;
  logic                      in_group_end;
  logic                      in_set_end;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_kept;
  logic                      out_out_of_range;
  logic [POS_W-1:0]          out_kept_position;
  logic signed [INDEX_W-1:0] out_removed_index;
  logic [COUNT_W-1:0]        out_group_kept_count;
  logic [COUNT_W-1:0]        out_group_removed_count;
  logic [NGW-1:0]            out_nonempty_groups;
  logic                      out_all_covered;
  logic                      out_summary_valid;

  // predictor state, a private copy of the filter's bitmap, tallies and register
  bit          seen_map [POSITION_DEPTH];
  int unsigned covered_count;
  int unsigned group_kept;
  int unsigned group_removed;
  int unsigned nonempty_count;
  logic [COUNT_W-1:0] num_positions_cfg;

  // outcomes predicted for accepted pairs, oldest first
  outcome_t pending_outcomes[$];

  // typed-in outcome that rides along with the pair currently on the bus
  bit       cur_has_outcome;
  outcome_t cur_outcome;

  // bookkeeping
  bit          quiet_tail;
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned n_pairs, n_kept, n_dupes, n_oor, n_sets, n_full_sets, n_cfg_writes;
  int unsigned n_typed;

  stim_row_t stimulus_table[$];

  // monitor scratch
  outcome_t want;
  outcome_t predicted;
  pair_t    seen_pair;

  coverage_bitmap_duplicate_filter DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_position             (in_position),
    .in_index_value          (in_index_value),
    .in_group_end            (in_group_end),
    .in_set_end              (in_set_end),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_kept                (out_kept),
    .out_out_of_range        (out_out_of_range),
    .out_kept_position       (out_kept_position),
    .out_removed_index       (out_removed_index),
    .out_group_kept_count    (out_group_kept_count),
    .out_group_removed_count (out_group_removed_count),
    .out_nonempty_groups     (out_nonempty_groups),
    .out_all_covered         (out_all_covered),
    .out_summary_valid       (out_summary_valid)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // clear the bitmap and set tallies, as after reset or a set end
  task automatic clear_set_state();
    for (int k = 0; k < POSITION_DEPTH; k++) seen_map[k] = 1'b0;
    covered_count  = 0;
    nonempty_count = 0;
  endtask

  // predict what the filter reports for one accepted pair and advance its state
  task automatic filter_pair(input pair_t p, output outcome_t r);
    bit set_last;
    bit group_last;
    bit bad;
    bit keep;
    set_last   = p.set_end;
    group_last = p.group_end || p.set_end;   // a set end closes the group too
    bad        = (int'(p.position) >= int'(num_positions_cfg)) ||
                 (int'(p.position) >= POSITION_DEPTH);
    keep       = 1'b0;
    r          = '0;

    // out-of-range pairs leave the bitmap and both group tallies alone
    if (!bad) begin
      if (seen_map[p.position]) begin
        if (group_removed < int'(cbdf_pkg::GROUP_COUNT_MAX)) group_removed++;
      end else begin
        keep = 1'b1;
        seen_map[p.position] = 1'b1;
        covered_count++;
        if (group_kept < int'(cbdf_pkg::GROUP_COUNT_MAX)) group_kept++;
      end
    end

    r.kept          = keep;
    r.out_of_range  = bad;
    r.kept_position = keep ? p.position : '0;
    r.removed_index = keep ? '0 : p.index_value;
    r.summary_valid = group_last;

    if (group_last) begin
      r.group_kept_count    = COUNT_W'(group_kept);
      r.group_removed_count = COUNT_W'(group_removed);
      if (group_kept > 0 && nonempty_count < MAX_GROUPS) nonempty_count++;
      group_kept    = 0;
      group_removed = 0;
    end

    // a register above the bitmap size can never be fully covered
    if (set_last) begin
      r.nonempty_groups = NGW'(nonempty_count);
      r.all_covered     = (covered_count == int'(num_positions_cfg));
      clear_set_state();
    end
  endtask

  task automatic compare_field(input string name, input logic [INDEX_W-1:0] expected,
                               input logic [INDEX_W-1:0] actual);
    if (expected !== actual) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      errors++;
    end
  endtask

  function automatic outcome_t make_outcome(
      input logic kept, input logic oor, input logic [POS_W-1:0] kp,
      input logic signed [INDEX_W-1:0] ri, input logic [COUNT_W-1:0] gk,
      input logic [COUNT_W-1:0] gr, input logic [NGW-1:0] ne, input logic ac,
      input logic sv);
    outcome_t r;
    r.kept                = kept;
    r.out_of_range        = oor;
    r.kept_position       = kp;
    r.removed_index       = ri;
    r.group_kept_count    = gk;
    r.group_removed_count = gr;
    r.nonempty_groups     = ne;
    r.all_covered         = ac;
    r.summary_valid       = sv;
    return r;
  endfunction

  task automatic add_row(input bit do_cfg, input logic [COUNT_W-1:0] cfg_value,
                         input logic [POS_W-1:0] pos, input logic signed [INDEX_W-1:0] idx,
                         input bit ge, input bit se, input bit has_outcome,
                         input outcome_t outcome);
    stim_row_t r;
    r.do_cfg      = do_cfg;
    r.cfg_value   = cfg_value;
    r.pair        = '{position: pos, index_value: idx, group_end: ge, set_end: se};
    r.has_outcome = has_outcome;
    r.outcome     = outcome;
    stimulus_table.push_back(r);
  endtask

  // monitor: results sampled and requests recorded at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      // result side first, a pair accepted now cannot have its result out yet
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kept=%0b pos=%0h idx=%0h",
                   $time, out_kept, out_kept_position, out_removed_index);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("kept", INDEX_W'(want.kept), INDEX_W'(out_kept));
          compare_field("out_of_range", INDEX_W'(want.out_of_range),
                        INDEX_W'(out_out_of_range));
          compare_field("kept_position", INDEX_W'(want.kept_position),
                        INDEX_W'(out_kept_position));
          compare_field("removed_index", want.removed_index, out_removed_index);
          compare_field("group_kept_count", INDEX_W'(want.group_kept_count),
                        INDEX_W'(out_group_kept_count));
          compare_field("group_removed_count", INDEX_W'(want.group_removed_count),
                        INDEX_W'(out_group_removed_count));
          compare_field("nonempty_groups", INDEX_W'(want.nonempty_groups),
                        INDEX_W'(out_nonempty_groups));
          compare_field("all_covered", INDEX_W'(want.all_covered),
                        INDEX_W'(out_all_covered));
          compare_field("summary_valid", INDEX_W'(want.summary_valid),
                        INDEX_W'(out_summary_valid));
        end
      end

      // accepted request: the predictor always runs so its state keeps step
      if (in_valid && !in_stall) begin
        seen_pair = '{position: in_position, index_value: in_index_value,
                      group_end: in_group_end, set_end: in_set_end};
        filter_pair(seen_pair, predicted);
        if (cur_has_outcome) begin
          pending_outcomes.push_back(cur_outcome);
          n_typed++;
        end else begin
          pending_outcomes.push_back(predicted);
        end
        n_pairs++;
        if (predicted.kept) n_kept++;
        else if (predicted.out_of_range) n_oor++;
        else n_dupes++;
        if (seen_pair.set_end) begin
          n_sets++;
          if (predicted.all_covered) n_full_sets++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_outcomes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure: random bursts of stall, none in the tail
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // hold off the sender until every outstanding result has come back
  task automatic drain_outcomes();
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // register write, only once no result is outstanding
  task automatic write_num_positions(input logic [COUNT_W-1:0] value);
    drain_outcomes();
    cfg_wr_data = value;
    cfg_wr_en   = 1'b1;
    @(posedge clk);
    num_positions_cfg = value;
    n_cfg_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // present one request at the falling edge and hold it until accepted
  task automatic send_pair(input pair_t p, input bit has_outcome, input outcome_t outcome);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_position     = p.position;
    in_index_value  = p.index_value;
    in_group_end    = p.group_end;
    in_set_end      = p.set_end;
    cur_has_outcome = has_outcome;
    cur_outcome     = outcome;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // mostly small registers so sets can be fully covered, now and then the extremes
  function automatic logic [COUNT_W-1:0] pick_num_positions();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COUNT_W'(POSITION_DEPTH);
      2:       return '1;
      3:       return COUNT_W'($urandom_range(0, 8191));
      default: return COUNT_W'($urandom_range(1, 48));
    endcase
  endfunction

  // random sets: well-formed groups with positions mostly around the configured
  // range, with a share of noise positions and short sets mixed in
  task automatic run_random_sets();
    int unsigned sent;
    int unsigned set_len;
    int unsigned span;
    pair_t       p;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ((sent == 0 || $urandom_range(0, 2) == 0) && sent < RANDOM_ITEMS - QUIET_ITEMS)
        write_num_positions(pick_num_positions());
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      if (num_positions_cfg == 0) span = 16;
      else if (num_positions_cfg <= 64) span = num_positions_cfg + num_positions_cfg / 4 + 2;
      else span = POSITION_DEPTH;
      for (int unsigned i = 0; i < set_len; i++) begin
        quiet_tail = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
        // now and then a register change in the middle of a set
        if (!quiet_tail && i != 0 && $urandom_range(0, 59) == 0)
          write_num_positions(pick_num_positions());
        // sender waits for the pipeline to empty once, mid-run
        if (sent == RANDOM_ITEMS / 2) drain_outcomes();
        p.position    = ($urandom_range(0, 7) == 0) ? POS_W'($urandom)
                                                    : POS_W'($urandom_range(0, span - 1));
        p.index_value = {$urandom, $urandom};
        p.group_end   = ($urandom_range(0, 3) == 0);
        p.set_end     = (i == set_len - 1);
        send_pair(p, 1'b0, NO_OUTCOME);
        sent++;
      end
    end
  endtask

  initial begin
    // every input known from time zero, reset asserted first
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_valid          = 1'b0;
    in_position       = '0;
    in_index_value    = '0;
    in_group_end      = 1'b0;
    in_set_end        = 1'b0;
    cur_has_outcome   = 1'b0;
    cur_outcome       = NO_OUTCOME;
    quiet_tail        = 1'b0;
    errors            = 0;
    cycle_count       = 0;
    n_pairs = 0; n_kept = 0; n_dupes = 0; n_oor = 0;
    n_sets = 0; n_full_sets = 0; n_cfg_writes = 0; n_typed = 0;
    num_positions_cfg = '0;
    group_kept        = 0;
    group_removed     = 0;
    clear_set_state();

    // directed table
    // register still zero after reset: everything out of range, zero positions covered
    add_row(1'b0, '0, 12'd0, INDEX_MAX, 1'b0, 1'b0, 1'b1,
            make_outcome(1'b0, 1'b1, '0, INDEX_MAX, '0, '0, '0, 1'b0, 1'b0));
    add_row(1'b0, '0, 12'd4095, INDEX_MIN, 1'b1, 1'b1, 1'b1,
            make_outcome(1'b0, 1'b1, '0, INDEX_MIN, '0, '0, '0, 1'b1, 1'b1));
    // four positions: first occurrence, then a repeat
    add_row(1'b1, 13'd4, 12'd0, 64'sd1, 1'b0, 1'b0, 1'b1,
            make_outcome(1'b1, 1'b0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
    add_row(1'b0, '0, 12'd0, -64'sd1, 1'b0, 1'b0, 1'b1,
            make_outcome(1'b0, 1'b0, '0, -64'sd1, '0, '0, '0, 1'b0, 1'b0));
    add_row(1'b0, '0, 12'd3, 64'sd5, 1'b1, 1'b0, 1'b0, NO_OUTCOME);
    add_row(1'b0, '0, 12'd4, 64'sd7, 1'b0, 1'b0, 1'b0, NO_OUTCOME);   // just past the range
    add_row(1'b0, '0, 12'd1, 64'sd9, 1'b0, 1'b0, 1'b0, NO_OUTCOME);
    add_row(1'b0, '0, 12'd2, 64'sd11, 1'b0, 1'b1, 1'b0, NO_OUTCOME);  // set end without group end
    // bitmap swept: the same position is kept again
    add_row(1'b0, '0, 12'd2, 64'sh5555_5555_5555_5555, 1'b1, 1'b0, 1'b0, NO_OUTCOME);
    // register raised mid-set, bits already set stay set
    add_row(1'b1, 13'd4096, 12'd4095, 64'shaaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, 1'b0,
            NO_OUTCOME);
    add_row(1'b0, '0, 12'd2, 64'sd13, 1'b0, 1'b0, 1'b0, NO_OUTCOME);
    add_row(1'b0, '0, 12'd4095, 64'sd15, 1'b1, 1'b1, 1'b0, NO_OUTCOME);
    // register above the bitmap size
    add_row(1'b1, 13'd8191, 12'd4095, 64'sd17, 1'b1, 1'b1, 1'b0, NO_OUTCOME);
    add_row(1'b1, 13'd0, 12'd4095, 64'sd0, 1'b1, 1'b1, 1'b1,
            make_outcome(1'b0, 1'b1, '0, 64'sd0, '0, '0, '0, 1'b1, 1'b1));
    // a group with only repeats does not count as nonempty
    add_row(1'b1, 13'd1, 12'd0, 64'sd19, 1'b1, 1'b0, 1'b0, NO_OUTCOME);
    add_row(1'b0, '0, 12'd0, 64'sd21, 1'b1, 1'b0, 1'b0, NO_OUTCOME);
    add_row(1'b0, '0, 12'd1, 64'sd23, 1'b0, 1'b1, 1'b0, NO_OUTCOME);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (stimulus_table[k]) begin
      if (stimulus_table[k].do_cfg) write_num_positions(stimulus_table[k].cfg_value);
      send_pair(stimulus_table[k].pair, stimulus_table[k].has_outcome,
                stimulus_table[k].outcome);
    end
    in_valid = 1'b0;
    cur_has_outcome = 1'b0;

    run_random_sets();
    in_valid = 1'b0;

    // wait out every outstanding result, then a settling wait for stray output
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("%0d pairs (%0d typed-in): %0d kept, %0d duplicates, %0d out of range",
             n_pairs, n_typed, n_kept, n_dupes, n_oor);
    $display("%0d set ends, %0d fully covered, %0d register writes, %0d cycles",
             n_sets, n_full_sets, n_cfg_writes, cycle_count);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
